### rtl/core/csps_pkg.sv
// csps_pkg: shared types and constants for the clock shadow page set.
// No dependencies; used by csps_cell and clock_shadow_page_set_core.
`default_nettype none
package csps_pkg;

    localparam int PAGE_OFS_W = 48;
    localparam int HIT_W      = 16;
    localparam int ACTION_W   = 2;

    localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_HALVE  = 2'd2;

    // Per-cell update strobes, one set per slot.
    typedef struct packed {
        logic wr;       // load new record, referenced bit cleared
        logic clr_ref;  // clock hand passed over this slot
        logic set_ref;  // search hit on this slot
        logic halve;    // scale-down of the hit count
    } cell_ctrl_t;

endpackage
`default_nettype wire

### rtl/core/clock_shadow_page_set_core.sv
// clock_shadow_page_set_core: clock (second chance) page set built as a row
// of csps_cell slots. Depends on csps_pkg and csps_cell.
//
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  in      | in_valid, in_ready, action, page_offset,  | in
//          | hit_count                                 |
//  out     | out_valid, out_ready, found, found_offset,| out
//          | found_hits                                |
//
// Flow: a transfer is captured into the input registers, then the slot
// compare, the priority chain through the cells and the clock hand victim
// pick run on the registered item; one item executes at a time, and a second
// can be captured while the first one's result waits.
// Reset: referenced bits, fill count, clock hand and handshake state clear;
// record payload is undefined until written.
// Stalls: the result sits in an output register; the next item is taken
// while it waits, and only execution holds until that register is free.
`default_nettype none
module clock_shadow_page_set_core #(
    parameter int SET_ENTRIES = 8,
    parameter int OFFSET_BITS = 48
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [csps_pkg::ACTION_W-1:0]       action,
    input  wire logic [csps_pkg::PAGE_OFS_W-1:0]     page_offset,
    input  wire logic [csps_pkg::HIT_W-1:0]          hit_count,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     found,
    output logic [csps_pkg::PAGE_OFS_W-1:0]          found_offset,
    output logic [csps_pkg::HIT_W-1:0]               found_hits
);

    localparam int N  = SET_ENTRIES;
    // Stored offset width: input field is 48 bits, so upper bits beyond it are zero.
    localparam int KB = (OFFSET_BITS < csps_pkg::PAGE_OFS_W) ? OFFSET_BITS
                                                               : csps_pkg::PAGE_OFS_W;
    localparam int HW = (N > 1) ? $clog2(N) : 1;
    localparam int CW = $clog2(N + 1);

    // ---------------------------------------------------------------- control
    logic                          busy_reg, busy_next;
    logic [csps_pkg::ACTION_W-1:0] act_reg;
    logic [KB-1:0]                 key_reg;
    logic [csps_pkg::HIT_W-1:0]    hin_reg;
    logic [CW-1:0]                 used_reg, used_next;
    logic [HW-1:0]                 hand_reg, hand_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          out_found_reg;
    logic [KB-1:0]                 out_ofs_reg;
    logic [csps_pkg::HIT_W-1:0]    out_hits_reg;

    logic in_xfer, exec, full;
    logic is_add, is_search, is_halve;

    assign in_ready  = !busy_reg;
    assign in_xfer   = in_valid && in_ready;
    // Execute once the output register is empty or draining this cycle.
    assign exec      = busy_reg && (!out_valid_reg || out_ready);
    assign full      = (used_reg == CW'(N));
    assign is_add    = (act_reg == csps_pkg::ACT_ADD);
    assign is_search = (act_reg == csps_pkg::ACT_SEARCH);
    assign is_halve  = (act_reg == csps_pkg::ACT_HALVE);

    // ---------------------------------------------------------------- cells
    csps_pkg::cell_ctrl_t          ctrl [N];
    logic [N:0]                    prior;
    logic [N-1:0]                  sel_vec, ref_vec, used_vec;
    logic [KB-1:0]                 cell_ofs  [N];
    logic [csps_pkg::HIT_W-1:0]    cell_hits [N];

    assign prior[0] = 1'b0;

    for (genvar g = 0; g < N; g++)
    begin : g_cell
        assign used_vec[g] = (CW'(g) < used_reg);

        csps_cell #(
            .OFS_W(KB)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .used      (used_vec[g]),
            .ctrl      (ctrl[g]),
            .key       (key_reg),
            .new_hits  (hin_reg),
            .prior_in  (prior[g]),
            .prior_out (prior[g+1]),
            .sel       (sel_vec[g]),
            .ref_bit   (ref_vec[g]),
            .ofs       (cell_ofs[g]),
            .hits      (cell_hits[g])
        );
    end

    // ---------------------------------------------------------------- victim
    // Hand advances before each look: first candidate is the slot after it.
    // Pick the first unreferenced slot above the hand, else the first from
    // slot 0; the slots skipped on the way lose their referenced bit.
    logic [N-1:0]  above, unref, cand_hi, pick, victim, clear_vec;
    logic [HW-1:0] hand_inc, victim_idx;
    logic          hi_hit, any_unref;

    assign hand_inc = (hand_reg == HW'(N - 1)) ? '0 : hand_reg + 1'b1;

    always_comb
    begin
        for (int i = 0; i < N; i++)
            above[i] = (HW'(i) > hand_reg);
    end

    assign unref     = ~ref_vec;
    assign cand_hi   = unref & above;
    assign hi_hit    = |cand_hi;
    assign any_unref = |unref;
    assign pick      = hi_hit ? cand_hi : unref;

    always_comb
    begin
        if (!any_unref)
        begin
            // Every slot referenced: one full turn clears all, slot after hand.
            victim    = N'(1) << hand_inc;
            clear_vec = '1;
        end
        else
        begin
            victim    = pick & (~pick + 1'b1);
            clear_vec = hi_hit ? (above & (victim - 1'b1))
                               : (above | (victim - 1'b1));
        end
    end

    always_comb
    begin
        victim_idx = '0;
        for (int i = 0; i < N; i++)
            if (victim[i])
                victim_idx = victim_idx | HW'(i);
    end

    // ---------------------------------------------------------------- cell strobes
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            ctrl[i].wr      = exec && is_add && (full ? victim[i] : (used_reg == CW'(i)));
            ctrl[i].clr_ref = exec && is_add && full && clear_vec[i];
            ctrl[i].set_ref = exec && is_search && sel_vec[i];
            ctrl[i].halve   = exec && is_halve && used_vec[i];
        end
    end

    // ---------------------------------------------------------------- result mux
    logic [KB-1:0]              sel_ofs;
    logic [csps_pkg::HIT_W-1:0] sel_hits;
    logic                       hit_any;

    assign hit_any = is_search && prior[N];

    always_comb
    begin
        sel_ofs  = '0;
        sel_hits = '0;
        for (int i = 0; i < N; i++)
        begin
            sel_ofs  = sel_ofs  | (cell_ofs[i]  & {KB{sel_vec[i]}});
            sel_hits = sel_hits | (cell_hits[i] & {csps_pkg::HIT_W{sel_vec[i]}});
        end
    end

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        busy_next      = busy_reg;
        used_next      = used_reg;
        hand_next      = hand_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (exec)
        begin
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
            if (is_add)
            begin
                if (full)
                    hand_next = victim_idx;
                else
                    used_next = used_reg + 1'b1;
            end
        end
        if (in_xfer)
            busy_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            used_reg      <= '0;
            hand_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            used_reg      <= used_next;
            hand_reg      <= hand_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: capture on transfer, result on execute.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            act_reg <= action;
            key_reg <= page_offset[KB-1:0];
            hin_reg <= hit_count;
        end
        if (exec)
        begin
            out_found_reg <= hit_any;
            out_ofs_reg   <= hit_any ? sel_ofs  : '0;
            out_hits_reg  <= hit_any ? sel_hits : '0;
        end
    end

    always_comb
    begin
        found_offset           = '0;
        found_offset[KB-1:0]   = out_ofs_reg;
    end

    assign out_valid  = out_valid_reg;
    assign found      = out_found_reg;
    assign found_hits = out_hits_reg;

    // ---------------------------------------------------------------- checks
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(N))
        else $error("fill count beyond set size");

    a_hand_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hand_reg <= HW'(N - 1))
        else $error("clock hand out of range");

    a_evict_clear: assert property (@(posedge clk) disable iff (!rst_n)
        exec && is_add && full |=> !ref_vec[hand_reg])
        else $error("evicted slot left referenced");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_found_reg |-> out_ofs_reg == '0 && out_hits_reg == '0)
        else $error("miss result carries data");

    a_one_sel: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(sel_vec) && (prior[N] == (|sel_vec)))
        else $error("priority chain selected more than one slot");

endmodule
`default_nettype wire

### rtl/core/csps_cell.sv
// csps_cell: one page record slot of the set, with its local offset compare
// and priority link to the next slot. Depends on csps_pkg.
`default_nettype none
module csps_cell #(
    parameter int OFS_W = 48
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     used,
    input  wire csps_pkg::cell_ctrl_t     ctrl,
    input  wire logic [OFS_W-1:0]         key,
    input  wire logic [csps_pkg::HIT_W-1:0] new_hits,
    input  wire logic                     prior_in,
    output logic                          prior_out,
    output logic                          sel,
    output logic                          ref_bit,
    output logic [OFS_W-1:0]              ofs,
    output logic [csps_pkg::HIT_W-1:0]    hits
);

    logic [OFS_W-1:0]           ofs_reg, ofs_next;
    logic [csps_pkg::HIT_W-1:0] hits_reg, hits_next;
    logic                       ref_reg, ref_next;
    logic                       match;

    assign match     = used && (ofs_reg == key);
    assign sel       = match && !prior_in;     // lowest matching slot wins
    assign prior_out = prior_in || match;

    always_comb
    begin
        ofs_next  = ofs_reg;
        hits_next = hits_reg;
        if (ctrl.wr)
        begin
            ofs_next  = key;
            hits_next = new_hits;
        end
        else if (ctrl.halve)
        begin
            hits_next = hits_reg >> 1;
        end
    end

    always_comb
    begin
        priority if (ctrl.wr || ctrl.clr_ref)
            ref_next = 1'b0;
        else if (ctrl.set_ref)
            ref_next = 1'b1;
        else
            ref_next = ref_reg;
    end

    always_ff @(posedge clk)
    begin
        ofs_reg  <= ofs_next;
        hits_reg <= hits_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ref_reg <= 1'b0;
        else
            ref_reg <= ref_next;
    end

    assign ref_bit = ref_reg;
    assign ofs     = ofs_reg;
    assign hits    = hits_reg;

endmodule
`default_nettype wire

### tb/sv/clock_shadow_page_set_core_tb.sv
// Self-checking testbench for clock_shadow_page_set_core (clock page replacement set).
// Needs csps_pkg and the core RTL. It drives random valid/ready traffic and checks
// every result against a built-in model of the page set or a typed expectation.
`timescale 1ns / 1ps

module clock_shadow_page_set_core_tb;

    // ------------------------------------------------------------------
    // Sizes and run control
    // ------------------------------------------------------------------
    localparam int SET_ENTRIES  = 8;
    localparam int OFFSET_BITS  = 48;
    localparam int RAND_ITEMS   = 1625;
    localparam int QUIET_TAIL   = 200;     // last transfers run with no idling
    localparam int HOLD_AT      = 300;     // accepted count that starts the long hold-off
    localparam int HOLD_CYCLES  = 250;
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_CYCLES = 400000;
    localparam int PRINT_CAP    = 20;

    // Action code 3 has no name in the package: it is a no-op.
    localparam logic [csps_pkg::ACTION_W-1:0] ACT_NONE = 2'd3;
    localparam logic [csps_pkg::PAGE_OFS_W-1:0] ALL_ONES = {csps_pkg::PAGE_OFS_W{1'b1}};

    typedef logic [csps_pkg::ACTION_W-1:0]   action_t;
    typedef logic [csps_pkg::PAGE_OFS_W-1:0] offset_t;
    typedef logic [csps_pkg::HIT_W-1:0]      hits_t;

    typedef struct packed {
        logic    found;
        offset_t offset;
        hits_t   hits;
    } lookup_result_t;

    typedef struct {
        action_t        act;
        offset_t        ofs;
        hits_t          hits;
        bit             typed;   // 1: expected value written into the row
        lookup_result_t want;
    } stim_row_t;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic    clk = 1'b0;
    logic    rst_n;
    logic    in_valid;
    logic    in_ready;
    action_t action;
    offset_t page_offset;
    hits_t   hit_count;
    logic    out_valid;
    logic    out_ready;
    logic    found;
    offset_t found_offset;
    hits_t   found_hits;

    clock_shadow_page_set_core #(
        .SET_ENTRIES(SET_ENTRIES),
        .OFFSET_BITS(OFFSET_BITS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .page_offset  (page_offset),
        .hit_count    (hit_count),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .found_offset (found_offset),
        .found_hits   (found_hits)
    );

    // 2 ns period: high 1 ns, low 1 ns.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Page set model state
    // ------------------------------------------------------------------
    offset_t page_ofs_mem [SET_ENTRIES];
    hits_t   page_hits_mem[SET_ENTRIES];
    bit      page_ref_mem [SET_ENTRIES];
    int      fill_count;
    int      hand_pos;

    lookup_result_t pending_results[$];   // one per accepted transfer, oldest first
    stim_row_t      directed_rows[$];

    int  mismatches;
    int  cycle_count;
    int  items_accepted;
    int  results_seen;
    int  search_hits;
    int  search_misses;
    int  evictions;
    int  halvings;
    bit  quiet;        // no idling on either side while set
    bit  hold_rx;      // long receiver hold-off in progress
    int  rx_stall_left;

    // Updates the model for one accepted transfer and returns the result it causes.
    task automatic page_set_apply(input action_t act, input offset_t ofs, input hits_t hits,
                                  output lookup_result_t res);
        int i;
        bit done;
        res  = '0;
        done = 1'b0;
        case (act)
            csps_pkg::ACT_ADD:
            begin
                if (fill_count < SET_ENTRIES)
                begin
                    page_ofs_mem[fill_count]  = ofs;
                    page_hits_mem[fill_count] = hits;
                    page_ref_mem[fill_count]  = 1'b0;
                    fill_count++;
                end
                else
                begin
                    // Hand advances before each look; referenced slots get a second chance.
                    for (i = 0; i < 2 * SET_ENTRIES && !done; i++)
                    begin
                        hand_pos = (hand_pos + 1) % SET_ENTRIES;
                        if (page_ref_mem[hand_pos])
                            page_ref_mem[hand_pos] = 1'b0;
                        else
                        begin
                            page_ofs_mem[hand_pos]  = ofs;
                            page_hits_mem[hand_pos] = hits;
                            page_ref_mem[hand_pos]  = 1'b0;
                            evictions++;
                            done = 1'b1;
                        end
                    end
                end
            end
            csps_pkg::ACT_SEARCH:
            begin
                // Lowest matching index wins.
                for (i = 0; i < fill_count && !done; i++)
                begin
                    if (page_ofs_mem[i] == ofs)
                    begin
                        page_ref_mem[i] = 1'b1;
                        res.found  = 1'b1;
                        res.offset = page_ofs_mem[i];
                        res.hits   = page_hits_mem[i];
                        done       = 1'b1;
                    end
                end
                if (done)
                    search_hits++;
                else
                    search_misses++;
            end
            csps_pkg::ACT_HALVE:
            begin
                for (i = 0; i < fill_count; i++)
                    page_hits_mem[i] = page_hits_mem[i] >> 1;
                halvings++;
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < PRINT_CAP)
            $display("[%0d] mismatch on %s: got 'h%0h, want 'h%0h", cycle_count, what, got,
                     want);
        mismatches++;
    endtask

    task automatic add_row(input action_t act, input offset_t ofs, input hits_t hits,
                           input bit typed, input logic f, input offset_t eo, input hits_t eh);
        stim_row_t row;
        row.act         = act;
        row.ofs         = ofs;
        row.hits        = hits;
        row.typed       = typed;
        row.want.found  = f;
        row.want.offset = eo;
        row.want.hits   = eh;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // Offers one transfer, starting at a falling edge, and returns at the falling
    // edge after it is accepted. An optional idle burst comes first. in_valid gets
    // one assignment per time step, so back-to-back items keep it high.
    task automatic send_item(input action_t act, input offset_t ofs, input hits_t hits,
                             input bit typed, input lookup_result_t typed_want);
        lookup_result_t res;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        page_offset <= ofs;
        hit_count   <= hits;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // Transfer taken on this edge: predict now, in acceptance order.
        page_set_apply(act, ofs, hits, res);
        pending_results.insert(pending_results.size(), typed ? typed_want : res);
        items_accepted++;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, plus the long hold-off below.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rx_stall_left > 0)
            rx_stall_left--;
        else if (!quiet && $urandom_range(0, 5) == 0)
            rx_stall_left = $urandom_range(1, 19);
        out_ready <= (rx_stall_left == 0) && !hold_rx;
    end

    // Long hold-off: the sender keeps offering, so the core fills up and
    // drops in_ready until the output side is released.
    initial
    begin
        hold_rx = 1'b0;
        wait (items_accepted >= HOLD_AT);
        @(posedge clk);
        hold_rx = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
    end

    // ------------------------------------------------------------------
    // Result checker: each output transfer against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        lookup_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch("result with no transfer pending", {15'd0, found, found_offset},
                                64'd0);
            else
            begin
                want = pending_results.pop_front();
                if (found !== want.found)
                    report_mismatch("found", 64'(found), 64'(want.found));
                if (found_offset !== want.offset)
                    report_mismatch("found_offset", 64'(found_offset), 64'(want.offset));
                if (found_hits !== want.hits)
                    report_mismatch("found_hits", 64'(found_hits), 64'(want.hits));
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     pending_results.size());
            $display("clock_shadow_page_set_core_tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int             n;
        int             pick;
        stim_row_t      row;
        offset_t        ofs;
        hits_t          hits;
        action_t        act;
        lookup_result_t none;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        action         = csps_pkg::ACT_ADD;
        page_offset    = '0;
        hit_count      = '0;
        out_ready      = 1'b0;
        quiet          = 1'b0;
        rx_stall_left  = 0;
        mismatches     = 0;
        cycle_count    = 0;
        items_accepted = 0;
        results_seen   = 0;
        search_hits    = 0;
        search_misses  = 0;
        evictions      = 0;
        halvings       = 0;
        fill_count     = 0;
        hand_pos       = 0;
        none           = '0;
        for (n = 0; n < SET_ENTRIES; n++)
        begin
            page_ofs_mem[n]  = '0;
            page_hits_mem[n] = '0;
            page_ref_mem[n]  = 1'b0;
        end

        // Directed rows. Typed expectations only where obvious: empty set,
        // no-op, adds and halves (all zero), and extreme records.
        add_row(csps_pkg::ACT_SEARCH, '0, '0, 1, 1'b0, '0, '0);           // empty set miss
        add_row(ACT_NONE, ALL_ONES, 16'hFFFF, 1, 1'b0, '0, '0);           // no-op action
        add_row(csps_pkg::ACT_HALVE, '0, '0, 1, 1'b0, '0, '0);            // halve empty set
        add_row(csps_pkg::ACT_ADD, '0, '0, 1, 1'b0, '0, '0);
        add_row(csps_pkg::ACT_ADD, ALL_ONES, 16'hFFFF, 1, 1'b0, '0, '0);
        add_row(csps_pkg::ACT_SEARCH, ALL_ONES, '0, 1, 1'b1, ALL_ONES, 16'hFFFF);
        add_row(csps_pkg::ACT_HALVE, '0, '0, 1, 1'b0, '0, '0);
        add_row(csps_pkg::ACT_SEARCH, ALL_ONES, '0, 1, 1'b1, ALL_ONES, 16'h7FFF); // round down
        // Fill the remaining slots.
        add_row(csps_pkg::ACT_ADD, 48'h5555_5555_5555, 16'h1234, 1, 1'b0, '0, '0);
        add_row(csps_pkg::ACT_ADD, 48'hAAAA_AAAA_AAAA, 16'h8000, 1, 1'b0, '0, '0);
        add_row(csps_pkg::ACT_ADD, 48'h0000_0000_0001, 16'h0001, 1, 1'b0, '0, '0);
        add_row(csps_pkg::ACT_ADD, 48'h8000_0000_0000, 16'h7FFF, 1, 1'b0, '0, '0);
        add_row(csps_pkg::ACT_ADD, 48'h0123_4567_89AB, 16'h00FF, 1, 1'b0, '0, '0);
        add_row(csps_pkg::ACT_ADD, 48'hFEDC_BA98_7654, 16'hFF00, 1, 1'b0, '0, '0);
        // Reference every slot so the next add sweeps a full turn.
        add_row(csps_pkg::ACT_SEARCH, '0, '0, 0, 1'b0, '0, '0);
        add_row(csps_pkg::ACT_SEARCH, ALL_ONES, '0, 0, 1'b0, '0, '0);
        add_row(csps_pkg::ACT_SEARCH, 48'h5555_5555_5555, '0, 0, 1'b0, '0, '0);
        add_row(csps_pkg::ACT_SEARCH, 48'hAAAA_AAAA_AAAA, '0, 0, 1'b0, '0, '0);
        add_row(csps_pkg::ACT_SEARCH, 48'h0000_0000_0001, '0, 0, 1'b0, '0, '0);
        add_row(csps_pkg::ACT_SEARCH, 48'h8000_0000_0000, '0, 0, 1'b0, '0, '0);
        add_row(csps_pkg::ACT_SEARCH, 48'h0123_4567_89AB, '0, 0, 1'b0, '0, '0);
        add_row(csps_pkg::ACT_SEARCH, 48'hFEDC_BA98_7654, '0, 0, 1'b0, '0, '0);
        // All referenced, hand at reset: bits all clear, page lands in slot 1.
        add_row(csps_pkg::ACT_ADD, 48'h0000_DEAD_BEEF, 16'h4321, 1, 1'b0, '0, '0);
        add_row(csps_pkg::ACT_SEARCH, ALL_ONES, '0, 1, 1'b0, '0, '0);     // evicted
        // Duplicate offset goes in slot 2; search still returns slot 0.
        add_row(csps_pkg::ACT_ADD, '0, 16'h0009, 1, 1'b0, '0, '0);
        add_row(csps_pkg::ACT_SEARCH, '0, '0, 0, 1'b0, '0, '0);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_item(row.act, row.ofs, row.hits, row.typed, row.want);
        end

        // Random part: mostly lookups of resident pages and fresh adds, so the
        // set stays full and the hand keeps turning; some misses and noise.
        for (n = 0; n < RAND_ITEMS; n++)
        begin
            quiet = (n >= RAND_ITEMS - QUIET_TAIL) || (n % 400 >= 340);
            pick  = $urandom_range(0, 99);
            ofs   = {16'($urandom), 32'($urandom)};
            hits  = 16'($urandom);
            if (pick < 40 && fill_count > 0)
            begin
                act = csps_pkg::ACT_SEARCH;
                ofs = page_ofs_mem[$urandom_range(0, fill_count - 1)];
            end
            else if (pick < 50)
                act = csps_pkg::ACT_SEARCH;
            else if (pick < 80)
            begin
                act = csps_pkg::ACT_ADD;
                if (pick >= 75 && fill_count > 0)
                    ofs = page_ofs_mem[$urandom_range(0, fill_count - 1)];
            end
            else if (pick < 92)
                act = csps_pkg::ACT_HALVE;
            else if (pick < 95)
                act = ACT_NONE;
            else
            begin
                // Small offsets collide often.
                act = pick[0] ? csps_pkg::ACT_ADD : csps_pkg::ACT_SEARCH;
                ofs = offset_t'($urandom_range(0, 3));
            end
            send_item(act, ofs, hits, 1'b0, none);
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d transfers in, %0d results out over %0d cycles", items_accepted,
                 results_seen, cycle_count);
        $display("search hits %0d, misses %0d, evictions %0d, halvings %0d", search_hits,
                 search_misses, evictions, halvings);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("clock_shadow_page_set_core_tb: PASS");
        else
            $display("clock_shadow_page_set_core_tb: FAIL");
        $finish;
    end

endmodule

### sim.f
rtl/core/csps_pkg.sv
rtl/core/csps_cell.sv
rtl/core/clock_shadow_page_set_core.sv
tb/sv/clock_shadow_page_set_core_tb.sv
